// ===== rtl/mbrd_pkg.sv =====
// package for the modbus rtu response deframer
// holds result kinds, frame constants, the result struct and the crc-16 byte step
// no dependencies
`timescale 1ns / 1ps

package mbrd_pkg;

  localparam int unsigned POS_W = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_FIRST = 8'd1;
  localparam logic [7:0] FC_READ_LAST  = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL = 8'd5;
  localparam logic [7:0] FC_WRITE_REG  = 8'd6;

  // frame positions that do not depend on the byte count
  localparam logic [POS_W-1:0] POS_DEVICE   = 9'd0;
  localparam logic [POS_W-1:0] POS_FUNCTION = 9'd1;
  localparam logic [POS_W-1:0] POS_BODY0    = 9'd2;
  localparam logic [POS_W-1:0] POS_BODY1    = 9'd3;
  localparam logic [POS_W-1:0] POS_BODY2    = 9'd4;
  localparam logic [POS_W-1:0] POS_BODY3    = 9'd5;
  localparam logic [POS_W-1:0] POS_BODY4    = 9'd6;
  localparam logic [POS_W-1:0] POS_BODY5    = 9'd7;

  typedef enum logic [2:0] {
    KIND_PAYLOAD     = 3'd0,
    KIND_READ_DONE   = 3'd1,
    KIND_WRITE_DONE  = 3'd2,
    KIND_EXCEPTION   = 3'd3,
    KIND_UNSUPPORTED = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [7:0]  byte_count;
    logic [15:0] echo_addr;
    logic [15:0] reg_value;
    logic [7:0]  exception_code;
    logic        crc_ok;
    logic        frame_end;
  } result_t;

  // reflected crc-16, one byte folded in
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbrd_in_stage.sv =====
// input register of the deframer: holds one received byte request
// depends on nothing but the handshake from the top level
`timescale 1ns / 1ps

module mbrd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  assign in_ready_o = !vld_q || advance_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign held_valid_o = vld_q;
  assign held_byte_o  = byte_q;

endmodule

// ===== rtl/mbrd_engine.sv =====
// frame tracking and crc engine: one byte per advance, at most one result
// depends on mbrd_pkg
`timescale 1ns / 1ps

module mbrd_engine
  import mbrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       dev_q, dev_d;
  logic [7:0]       fc_q, fc_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       exc_q, exc_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic [15:0]      addr_q, addr_d;
  logic [15:0]      val_q, val_d;

  logic             clear;
  logic [15:0]      crc_next;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] data_idx;
  logic             crc_match;
  logic             fc_supported;

  assign crc_next     = crc_byte(crc_q, byte_i);
  assign len_ext      = {1'b0, len_q};
  assign data_idx     = pos_q - POS_BODY1;
  assign crc_match    = ({byte_i, crc_lo_q} == crc_q);
  assign fc_supported = byte_i[7] || (byte_i >= FC_READ_FIRST && byte_i <= FC_WRITE_REG);

  always_comb begin
    pos_d    = pos_q;
    dev_d    = dev_q;
    fc_d     = fc_q;
    len_d    = len_q;
    exc_d    = exc_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    addr_d   = addr_q;
    val_d    = val_q;
    clear    = 1'b0;

    res_valid_o         = 1'b0;
    res_o               = '0;
    res_o.kind          = KIND_PAYLOAD;
    res_o.slave_id      = dev_q;
    res_o.function_code = fc_q;
    res_o.frame_end     = 1'b1;

    if (pos_q == POS_DEVICE) begin
      dev_d = byte_i;
      crc_d = crc_next;
      pos_d = POS_FUNCTION;
    end else if (pos_q == POS_FUNCTION) begin
      fc_d  = byte_i;
      crc_d = crc_next;
      if (fc_supported) begin
        pos_d = POS_BODY0;
      end else begin
        res_valid_o         = 1'b1;
        res_o.kind          = KIND_UNSUPPORTED;
        res_o.function_code = byte_i;
        clear               = 1'b1;
      end
    end else if (fc_q[7]) begin
      // exception response
      if (pos_q == POS_BODY0) begin
        exc_d = byte_i;
        crc_d = crc_next;
        pos_d = POS_BODY1;
      end else if (pos_q == POS_BODY1) begin
        crc_lo_d = byte_i;
        pos_d    = POS_BODY2;
      end else if (pos_q == POS_BODY2) begin
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_EXCEPTION;
        res_o.exception_code = exc_q;
        res_o.crc_ok         = crc_match;
        clear                = 1'b1;
      end else begin
        clear = 1'b1;
      end
    end else if (fc_q >= FC_READ_FIRST && fc_q <= FC_READ_LAST) begin
      // read response
      if (pos_q == POS_BODY0) begin
        len_d = byte_i;
        crc_d = crc_next;
        pos_d = POS_BODY1;
      end else if (pos_q < POS_BODY1 + len_ext) begin
        crc_d               = crc_next;
        res_valid_o         = 1'b1;
        res_o.kind          = KIND_PAYLOAD;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = data_idx[7:0];
        res_o.byte_count    = len_q;
        res_o.frame_end     = 1'b0;
        pos_d               = pos_q + 9'd1;
      end else if (pos_q == POS_BODY1 + len_ext) begin
        crc_lo_d = byte_i;
        pos_d    = pos_q + 9'd1;
      end else if (pos_q == POS_BODY2 + len_ext) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_READ_DONE;
        res_o.byte_count = len_q;
        res_o.crc_ok     = crc_match;
        clear            = 1'b1;
      end else begin
        clear = 1'b1;
      end
    end else if (fc_q == FC_WRITE_COIL || fc_q == FC_WRITE_REG) begin
      // single write echo
      if (pos_q >= POS_BODY0 && pos_q <= POS_BODY3) begin
        crc_d = crc_next;
        pos_d = pos_q + 9'd1;
        if (pos_q == POS_BODY0) begin
          addr_d = {byte_i, 8'h00};
        end else if (pos_q == POS_BODY1) begin
          addr_d = {addr_q[15:8], byte_i};
        end else if (pos_q == POS_BODY2) begin
          val_d = {byte_i, 8'h00};
        end else begin
          val_d = {val_q[15:8], byte_i};
        end
      end else if (pos_q == POS_BODY4) begin
        crc_lo_d = byte_i;
        pos_d    = POS_BODY5;
      end else if (pos_q == POS_BODY5) begin
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_WRITE_DONE;
        res_o.echo_addr = addr_q;
        res_o.reg_value = val_q;
        res_o.crc_ok    = crc_match;
        clear           = 1'b1;
      end else begin
        clear = 1'b1;
      end
    end else begin
      clear = 1'b1;
    end

    if (clear) begin
      pos_d    = POS_DEVICE;
      dev_d    = '0;
      fc_d     = '0;
      len_d    = '0;
      exc_d    = '0;
      crc_d    = CRC_INIT;
      crc_lo_d = '0;
      addr_d   = '0;
      val_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_DEVICE;
      dev_q    <= '0;
      fc_q     <= '0;
      len_q    <= '0;
      exc_q    <= '0;
      crc_q    <= CRC_INIT;
      crc_lo_q <= '0;
      addr_q   <= '0;
      val_q    <= '0;
    end else if (advance_i) begin
      pos_q    <= pos_d;
      dev_q    <= dev_d;
      fc_q     <= fc_d;
      len_q    <= len_d;
      exc_q    <= exc_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      addr_q   <= addr_d;
      val_q    <= val_d;
    end
  end

  // no frame type reaches past the second crc byte of a full read
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_BODY2 + 9'd255)
    else $error("frame position out of range");

  // a frame returns to its start after reporting its end
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && res_o.frame_end |=> pos_q == POS_DEVICE && crc_q == CRC_INIT)
    else $error("frame state not cleared after frame end");

  // a read keeps its position inside the announced length plus crc
  a_read_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fc_q[7] && fc_q >= FC_READ_FIRST && fc_q <= FC_READ_LAST && pos_q > POS_BODY1
      |-> pos_q <= POS_BODY2 + len_ext)
    else $error("read frame position beyond crc");

endmodule

// ===== rtl/mbrd_out_stage.sv =====
// result register of the deframer: holds one result until taken
// depends on mbrd_pkg
`timescale 1ns / 1ps

module mbrd_out_stage
  import mbrd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/modbus_rtu_response_deframer.sv =====
// Modbus RTU response deframer with running CRC-16 check.
//
// Input channel: one response byte per request on rx_byte_i, handshake
// in_valid_i / in_ready_o. Output channel: one result per request on the
// result ports, handshake out_valid_o / out_ready_i. Read responses give
// one payload result per data byte and a read-done result after the CRC;
// single-write echoes give address and value; exceptions give the code;
// an unknown function code is reported on its own byte and the next byte
// starts a new frame. frame_end_o marks the last result of a frame and
// crc_ok_o tells whether the received CRC matched.
//
// A byte accepted into the input register is decoded by the engine and, if
// it yields a result, the result is loaded into the result register that
// drives the ports. Throughput: one byte per cycle while the receiver keeps
// out_ready_i high; the CRC step is an unrolled combinational byte update.
// When the receiver stalls, the result register holds its result and
// in_ready_o stays high until the input register is also full.
// Reset clears the valid flags of both registers and returns the frame state to its start.
`timescale 1ns / 1ps

module modbus_rtu_response_deframer
  import mbrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  slave_id_o,
  output logic [7:0]  function_code_o,
  output logic [7:0]  byte_count_o,
  output logic [15:0] echo_addr_o,
  output logic [15:0] reg_value_o,
  output logic [7:0]  exception_code_o,
  output logic        crc_ok_o,
  output logic        frame_end_o
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance = held_valid && (!out_valid_o || out_ready_i);

  mbrd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .advance_i   (advance),
    .held_valid_o(held_valid),
    .held_byte_o (held_byte)
  );

  mbrd_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .byte_i     (held_byte),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  mbrd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .res_i      (res),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .res_o      (out_res)
  );

  assign kind_o           = out_res.kind;
  assign payload_byte_o   = out_res.payload_byte;
  assign payload_index_o  = out_res.payload_index;
  assign slave_id_o       = out_res.slave_id;
  assign function_code_o  = out_res.function_code;
  assign byte_count_o     = out_res.byte_count;
  assign echo_addr_o      = out_res.echo_addr;
  assign reg_value_o      = out_res.reg_value;
  assign exception_code_o = out_res.exception_code;
  assign crc_ok_o         = out_res.crc_ok;
  assign frame_end_o      = out_res.frame_end;

  a_end_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_end_o == (kind_o != KIND_PAYLOAD))
    else $error("frame end flag disagrees with result kind");

  a_crc_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_ok_o |-> frame_end_o && kind_o != KIND_UNSUPPORTED)
    else $error("crc status on a result that carries none");

  a_index_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PAYLOAD |-> payload_index_o < byte_count_o)
    else $error("payload index beyond announced count");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("stalled result lost");

endmodule

// ===== sim/testbench.sv =====
// testbench for modbus_rtu_response_deframer: directed and random response frames
// a local frame decoder predicts every result, which is checked field by field
// depends on mbrd_pkg and the deframer rtl
`timescale 1ns / 1ps

module testbench;
  import mbrd_pkg::*;

  localparam int ITEM_COUNT = 1050;
  localparam int QUIET_ITEMS = 120;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic [7:0]  rx_byte;
  logic        out_valid_o;
  logic        out_ready;
  logic [2:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  payload_index_o;
  logic [7:0]  slave_id_o;
  logic [7:0]  function_code_o;
  logic [7:0]  byte_count_o;
  logic [15:0] echo_addr_o;
  logic [15:0] reg_value_o;
  logic [7:0]  exception_code_o;
  logic        crc_ok_o;
  logic        frame_end_o;

  modbus_rtu_response_deframer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .slave_id_o      (slave_id_o),
    .function_code_o (function_code_o),
    .byte_count_o    (byte_count_o),
    .echo_addr_o     (echo_addr_o),
    .reg_value_o     (reg_value_o),
    .exception_code_o(exception_code_o),
    .crc_ok_o        (crc_ok_o),
    .frame_end_o     (frame_end_o)
  );

  // decoder state of the frame in flight
  logic [POS_W-1:0] fr_pos;
  logic [7:0]       fr_dev;
  logic [7:0]       fr_func;
  logic [7:0]       fr_len;
  logic [7:0]       fr_exc;
  logic [15:0]      fr_crc;
  logic [7:0]       fr_crc_lo;
  logic [15:0]      fr_addr;
  logic [15:0]      fr_value;

  result_t    decoded_results[$];
  logic [7:0] frame_buf[$];
  int         fail_count;
  int         sent_count;
  int         stall_cycles;
  bit         quiet_tail;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic restart_frame();
    fr_pos = POS_DEVICE;
    fr_dev = '0;
    fr_func = '0;
    fr_len = '0;
    fr_exc = '0;
    fr_crc = CRC_INIT;
    fr_crc_lo = '0;
    fr_addr = '0;
    fr_value = '0;
  endtask

  // folds one accepted byte into the frame state and queues any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    result_t          r;
    logic             emit;
    logic             done;
    logic [POS_W-1:0] data_end;
    r = '0;
    emit = 1'b0;
    done = 1'b0;
    data_end = POS_BODY1 + {1'b0, fr_len};
    if (fr_pos == POS_DEVICE) begin
      fr_dev = b;
      fr_crc = crc16_fold(fr_crc, b);
      fr_pos = POS_FUNCTION;
    end else if (fr_pos == POS_FUNCTION) begin
      fr_func = b;
      fr_crc = crc16_fold(fr_crc, b);
      if (b[7] || (b >= FC_READ_FIRST && b <= FC_WRITE_REG)) begin
        fr_pos = POS_BODY0;
      end else begin
        r.kind = KIND_UNSUPPORTED;
        emit = 1'b1;
        done = 1'b1;
      end
    end else if (fr_func[7]) begin
      if (fr_pos == POS_BODY0) begin
        fr_exc = b;
        fr_crc = crc16_fold(fr_crc, b);
        fr_pos = POS_BODY1;
      end else if (fr_pos == POS_BODY1) begin
        fr_crc_lo = b;
        fr_pos = POS_BODY2;
      end else if (fr_pos == POS_BODY2) begin
        r.kind = KIND_EXCEPTION;
        r.exception_code = fr_exc;
        r.crc_ok = ({b, fr_crc_lo} == fr_crc);
        emit = 1'b1;
        done = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else if (fr_func >= FC_READ_FIRST && fr_func <= FC_READ_LAST) begin
      if (fr_pos == POS_BODY0) begin
        fr_len = b;
        fr_crc = crc16_fold(fr_crc, b);
        fr_pos = POS_BODY1;
      end else if (fr_pos < data_end) begin
        fr_crc = crc16_fold(fr_crc, b);
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = 8'(fr_pos - POS_BODY1);
        r.byte_count = fr_len;
        emit = 1'b1;
        fr_pos = fr_pos + 1'b1;
      end else if (fr_pos == data_end) begin
        fr_crc_lo = b;
        fr_pos = fr_pos + 1'b1;
      end else if (fr_pos == data_end + 1'b1) begin
        r.kind = KIND_READ_DONE;
        r.byte_count = fr_len;
        r.crc_ok = ({b, fr_crc_lo} == fr_crc);
        emit = 1'b1;
        done = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else if (fr_func == FC_WRITE_COIL || fr_func == FC_WRITE_REG) begin
      if (fr_pos >= POS_BODY0 && fr_pos <= POS_BODY3) begin
        fr_crc = crc16_fold(fr_crc, b);
        case (fr_pos)
          POS_BODY0: begin
            fr_addr[15:8] = b;
          end
          POS_BODY1: begin
            fr_addr[7:0] = b;
          end
          POS_BODY2: begin
            fr_value[15:8] = b;
          end
          default: begin
            fr_value[7:0] = b;
          end
        endcase
        fr_pos = fr_pos + 1'b1;
      end else if (fr_pos == POS_BODY4) begin
        fr_crc_lo = b;
        fr_pos = POS_BODY5;
      end else if (fr_pos == POS_BODY5) begin
        r.kind = KIND_WRITE_DONE;
        r.echo_addr = fr_addr;
        r.reg_value = fr_value;
        r.crc_ok = ({b, fr_crc_lo} == fr_crc);
        emit = 1'b1;
        done = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else begin
      done = 1'b1;
    end
    if (emit) begin
      r.slave_id = fr_dev;
      r.function_code = fr_func;
      r.frame_end = (r.kind != KIND_PAYLOAD);
      decoded_results.push_back(r);
    end
    if (done) begin
      restart_frame();
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b);
    sent_count++;
  endtask

  task automatic start_frame(input logic [7:0] dev, input logic [7:0] fc);
    frame_buf = {};
    frame_buf.push_back(dev);
    frame_buf.push_back(fc);
  endtask

  // appends the crc, low byte first, and sends the first keep bytes (all if keep < 0)
  task automatic send_frame(input bit bad_crc, input int keep);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (frame_buf[i]) crc = crc16_fold(crc, frame_buf[i]);
    if (bad_crc) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
    if (keep < 0 || keep > frame_buf.size()) begin
      keep = frame_buf.size();
    end
    for (int i = 0; i < keep; i++) begin
      send_byte(frame_buf[i]);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (decoded_results.size() != 0);
  endtask

  task automatic send_read_frame(input int len, input bit bad_crc, input int keep);
    start_frame(8'($urandom), 8'($urandom_range(FC_READ_FIRST, FC_READ_LAST)));
    frame_buf.push_back(8'(len));
    repeat (len) frame_buf.push_back(8'($urandom));
    send_frame(bad_crc, keep);
  endtask

  task automatic send_random_frame();
    int   pick;
    int   len;
    int   keep;
    bit   bad_crc;
    logic [7:0] fc;
    pick = $urandom_range(0, 99);
    bad_crc = ($urandom_range(0, 99) < 15);
    keep = -1;
    if (pick >= 85 && pick < 93) begin
      // broken frame, cut short
      keep = $urandom_range(1, 6);
      pick = $urandom_range(0, 74);
    end
    if (pick < 30) begin
      if ($urandom_range(0, 39) == 0) begin
        len = 255;
      end else if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(0, 8);
      end
      send_read_frame(len, bad_crc, keep);
    end else if (pick < 55) begin
      start_frame(8'($urandom), $urandom_range(0, 1) ? FC_WRITE_COIL : FC_WRITE_REG);
      repeat (4) frame_buf.push_back(8'($urandom));
      send_frame(bad_crc, keep);
    end else if (pick < 75) begin
      start_frame(8'($urandom), {1'b1, 7'($urandom)});
      frame_buf.push_back(8'($urandom));
      send_frame(bad_crc, keep);
    end else if (pick < 85) begin
      do fc = 8'($urandom_range(0, 127)); while (fc >= FC_READ_FIRST && fc <= FC_WRITE_REG);
      send_byte(8'($urandom));
      send_byte(fc);
    end else begin
      // line noise
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end
  endtask

  task automatic test_read_responses();
    start_frame(8'h00, FC_READ_FIRST);
    frame_buf.push_back(8'h00);
    send_frame(1'b0, -1);
    start_frame(8'hFF, FC_READ_LAST);
    frame_buf.push_back(8'h02);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    send_frame(1'b1, -1);
  endtask

  task automatic test_write_echoes();
    start_frame(8'h11, FC_WRITE_REG);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    send_frame(1'b0, -1);
    start_frame(8'h22, FC_WRITE_COIL);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    send_frame(1'b1, -1);
  endtask

  task automatic test_exception();
    start_frame(8'h5A, 8'h83);
    frame_buf.push_back(8'h02);
    send_frame(1'b1, -1);
  endtask

  task automatic test_unsupported_codes();
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(8'h3C);
    send_byte(8'h07);
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      send_random_frame();
      wait_drain();
    end
  endtask

  task automatic test_random_traffic();
    // longest read frame first, index runs up to 254
    send_read_frame(255, 1'b0, -1);
    while (sent_count < ITEM_COUNT) begin
      if (sent_count >= ITEM_COUNT - QUIET_ITEMS) begin
        quiet_tail = 1'b1;
      end
      send_random_frame();
    end
  endtask

  // receiver side: ready with random stall bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (decoded_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", kind_o);
        fail_count++;
      end else begin
        want = decoded_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind_o));
        check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_o));
        check_field("payload_index", 16'(want.payload_index), 16'(payload_index_o));
        check_field("slave_id", 16'(want.slave_id), 16'(slave_id_o));
        check_field("function_code", 16'(want.function_code), 16'(function_code_o));
        check_field("byte_count", 16'(want.byte_count), 16'(byte_count_o));
        check_field("echo_addr", want.echo_addr, echo_addr_o);
        check_field("reg_value", want.reg_value, reg_value_o);
        check_field("exception_code", 16'(want.exception_code), 16'(exception_code_o));
        check_field("crc_ok", 16'(want.crc_ok), 16'(crc_ok_o));
        check_field("frame_end", 16'(want.frame_end), 16'(frame_end_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= IDLE_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    fail_count = 0;
    sent_count = 0;
    stall_cycles = 0;
    quiet_tail = 1'b0;
    restart_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_read_responses();
    test_write_echoes();
    test_exception();
    test_unsupported_codes();
    test_sender_pause();
    test_random_traffic();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (decoded_results.size() != 0) begin
      $error("%0d expected results never arrived", decoded_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
